FILE: rtl/ils_pkg.sv
// Shared types, command and status codes, and helpers for the indexed list store.
package ils_pkg;

  // Default number of entries, and the widest index or count the design supports (8191 entries)
  localparam int DEPTH_DEFAULT = 64;
  localparam int CNT_W_MAX     = 13;
  localparam int WORD_W        = 32;

  typedef logic [CNT_W_MAX-1:0]     idx_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // Command codes on the command port
  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_POP_AT   = 3'd2,
    CMD_POP_LAST = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WRITE    = 3'd5
  } cmd_t;

  // Status codes on the status port
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What each cell does in a cycle, for cells whose index lies in [lo, hi]
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_t;

  // Broadcast control to the row of cells
  typedef struct packed {
    cell_op_t op;
    idx_t     lo;
    idx_t     hi;
    word_t    value;
  } cell_ctrl_t;

  // Smallest power of two that is at least n (1 for n of 0 or 1)
  function automatic idx_t ceil_pow2(idx_t n);
    idx_t m;
    idx_t r;
    m = n - idx_t'(1);
    r = idx_t'(1);
    if (n > idx_t'(1)) begin
      for (int b = 0; b < CNT_W_MAX; b++) begin
        if (m[b]) begin
          r = idx_t'(1) << (b + 1);
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/indexed_list_store_unit.sv
// Indexed list store: an ordered list of signed words held in a row of shifting cells.
//
// Usage:
//   Command channel: command, position and value are taken at a rising edge where start
//   is high and busy is low. busy stays low: a command may be issued in every cycle.
//   Result channel: done is high for exactly one cycle, the cycle after the command beat,
//   with result_value, status, length and logical_capacity valid in that cycle. The
//   receiver cannot hold results off; every beat must be taken when shown.
//   Throughput: one command per cycle. Insert and pop move every later entry by one place
//   in the same cycle, since each cell loads from its neighbour; the read path is a select
//   across the row.
//   length and logical_capacity show the list state after the most recent command.
//   Reset: synchronous, active high. The list becomes empty with a capacity of one and
//   no result is pending. Entry contents are not cleared; only entries below the
//   length are ever read.
module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              command,
  input  logic [CNT_W-1:0]        position,
  input  logic signed [WORD_W-1:0] value,
  output logic                    done,
  output logic signed [WORD_W-1:0] result_value,
  output logic [1:0]              status,
  output logic [CNT_W-1:0]        length,
  output logic [CNT_W-1:0]        logical_capacity
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] cap_next;
  logic [CNT_W-1:0] grown_cap;
  logic [CNT_W:0]   doubled_cap;
  logic [CNT_W-1:0] rd_idx;
  logic             accept;
  logic             full;
  word_t            rd_data;
  word_t            res_next;
  status_t          status_next;
  cell_ctrl_t       ctrl;
  word_t            cell_data [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign length = count;
  assign logical_capacity = cap;

  // Capacity after one doubling once the length reaches it, capped at the depth
  assign doubled_cap = {cap, 1'b0};
  always_comb begin
    grown_cap = cap;
    if (count >= cap) begin
      grown_cap = (doubled_cap > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH)
                                                       : doubled_cap[CNT_W-1:0];
    end
  end

  // Read select across the row
  assign rd_idx  = (cmd_t'(command) == CMD_POP_LAST) ? (count - CNT_W'(1)) : position;
  assign rd_data = cell_data[rd_idx[IDX_W-1:0]];

  // Command decode: cell control, next length and capacity, result
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.lo     = '0;
    ctrl.hi     = '0;
    ctrl.value  = value;
    count_next  = count;
    cap_next    = cap;
    res_next    = '0;
    status_next = ST_OK;
    if (accept) begin
      case (cmd_t'(command))
        CMD_APPEND: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_LOAD;
            ctrl.lo    = idx_t'(count);
            ctrl.hi    = idx_t'(count);
            count_next = count + CNT_W'(1);
            cap_next   = grown_cap;
          end
        end
        CMD_INSERT: begin
          if (position > count) begin
            status_next = ST_RANGE;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_SHIFT_UP;
            ctrl.lo    = idx_t'(position);
            ctrl.hi    = idx_t'(count);
            count_next = count + CNT_W'(1);
            cap_next   = grown_cap;
            // shrink check only for an insert in the middle
            if (position != count &&
                ((CNT_W + 2)'(count_next) << 2) < (CNT_W + 2)'(grown_cap)) begin
              cap_next = CNT_W'(ceil_pow2(idx_t'(count_next)));
            end
          end
        end
        CMD_POP_AT, CMD_POP_LAST: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else if (rd_idx >= count) begin
            status_next = ST_RANGE;
          end else begin
            res_next   = rd_data;
            count_next = count - CNT_W'(1);
            // later entries move down one place
            if ((rd_idx + CNT_W'(1)) < count) begin
              ctrl.op = CELL_SHIFT_DOWN;
              ctrl.lo = idx_t'(rd_idx);
              ctrl.hi = idx_t'(count) - idx_t'(2);
            end
            if (((CNT_W + 2)'(count_next) << 2) < (CNT_W + 2)'(cap)) begin
              cap_next = CNT_W'(ceil_pow2(idx_t'(count_next)));
            end
          end
        end
        CMD_READ: begin
          if (position >= count) begin
            status_next = ST_RANGE;
          end else begin
            res_next = rd_data;
          end
        end
        CMD_WRITE: begin
          if (position >= count) begin
            status_next = ST_RANGE;
          end else begin
            ctrl.op = CELL_LOAD;
            ctrl.lo = idx_t'(position);
            ctrl.hi = idx_t'(position);
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  // Row of cells, each linked to both neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    ils_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i])
    );
  end

  // List state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CNT_W'(1);
    end else begin
      count <= count_next;
      cap   <= cap_next;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_value <= res_next;
      status       <= status_next;
    end
  end

endmodule

FILE: rtl/ils_cell.sv
// One storage cell of the list: holds an entry and takes a neighbour's word on a shift.
module ils_cell
  import ils_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  word_t      left_data,
  input  word_t      right_data,
  output word_t      data
);

  logic  in_range;
  word_t data_next;

  // Is this cell inside the affected span
  assign in_range = (idx_t'(INDEX) >= ctrl.lo) && (idx_t'(INDEX) <= ctrl.hi);

  // Next entry value
  always_comb begin
    data_next = data;
    if (in_range) begin
      case (ctrl.op)
        CELL_LOAD:       data_next = ctrl.value;
        CELL_SHIFT_UP:   data_next = (idx_t'(INDEX) == ctrl.lo) ? ctrl.value : left_data;
        CELL_SHIFT_DOWN: data_next = right_data;
        default:         data_next = data;
      endcase
    end
  end

  // Entry register; contents are undefined until written
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: rtl/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
module ils_checker
  import ils_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic signed [WORD_W-1:0] result_value,
  input logic [1:0]               status,
  input logic [CNT_W-1:0]         length,
  input logic [CNT_W-1:0]         logical_capacity
);

  // Every command beat gives a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("command beat without result beat");

  // No result beat without a command beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result beat without command beat");

  // Failed commands return a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_value == '0))
    else $error("non-zero word with error status");

  // Capacity covers the length and stays within the depth
  a_cap_bounds: assert property (@(posedge clk) disable iff (rst)
    done |-> (length <= logical_capacity && logical_capacity != '0 &&
              logical_capacity <= CNT_W'(DEPTH)))
    else $error("capacity out of bounds");

  // A failed command leaves the length unchanged
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK && !$past(rst)) |-> (length == $past(length)))
    else $error("length changed on failed command");

endmodule

bind indexed_list_store_unit ils_checker #(
  .DEPTH (DEPTH)
) u_ils_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .result_value     (result_value),
  .status           (status),
  .length           (length),
  .logical_capacity (logical_capacity)
);

FILE: verif/testbench.sv
// Self-checking testbench for the indexed list store: directed table, then random command mix.
`timescale 1ns / 1ps

module testbench;
  import ils_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_MAX    = (1 << CNT_W) - 1;

  // Command codes the block leaves unused
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Traffic shapes for the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 1675;
  localparam int SEGMENT_LEN   = 120;
  localparam int PRINT_LIMIT   = 50;

  typedef struct packed {
    word_t            result_value;
    status_t          status;
    logic [CNT_W-1:0] length;
    logic [CNT_W-1:0] capacity;
  } list_reply_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [CNT_W-1:0] pos;
    word_t            val;
    logic             has_literal;
    list_reply_t      reply;
  } list_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              command = CMD_APPEND;
  logic [CNT_W-1:0]        position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                    done;
  logic signed [WORD_W-1:0] result_value;
  logic [1:0]              status;
  logic [CNT_W-1:0]        length;
  logic [CNT_W-1:0]        logical_capacity;

  // Shadow copy of the list
  word_t list_words [LIST_DEPTH];
  int    word_count = 0;
  int    cap_now    = 1;

  list_reply_t pending_replies [$];
  int          mismatch_count = 0;

  // Directed rows; a literal reply where it is obvious, otherwise the shadow list decides
  list_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,     7'd0,   32'sd0,           1'b1, '{32'sd0,           ST_RANGE, 7'd0, 7'd1}},
    '{CMD_POP_AT,   7'd0,   32'sd0,           1'b1, '{32'sd0,           ST_EMPTY, 7'd0, 7'd1}},
    '{CMD_POP_LAST, 7'd0,   32'sd0,           1'b1, '{32'sd0,           ST_EMPTY, 7'd0, 7'd1}},
    '{CMD_WRITE,    7'd0,   32'sd5,           1'b1, '{32'sd0,           ST_RANGE, 7'd0, 7'd1}},
    '{CMD_INSERT,   7'd1,   32'sd9,           1'b1, '{32'sd0,           ST_RANGE, 7'd0, 7'd1}},
    '{CMD_APPEND,   7'd0,   32'sh7fffffff,    1'b1, '{32'sd0,           ST_OK,    7'd1, 7'd1}},
    '{CMD_APPEND,   7'd127, 32'sh80000000,    1'b1, '{32'sd0,           ST_OK,    7'd2, 7'd2}},
    '{CMD_INSERT,   7'd2,   -32'sd1,          1'b1, '{32'sd0,           ST_OK,    7'd3, 7'd4}},
    '{CMD_INSERT,   7'd0,   32'sd0,           1'b1, '{32'sd0,           ST_OK,    7'd4, 7'd4}},
    '{CMD_READ,     7'd1,   32'sd0,           1'b1, '{32'sh7fffffff,    ST_OK,    7'd4, 7'd4}},
    '{CMD_READ,     7'd127, 32'sd0,           1'b1, '{32'sd0,           ST_RANGE, 7'd4, 7'd4}},
    '{CMD_WRITE,    7'd3,   32'sd12345,       1'b1, '{32'sd0,           ST_OK,    7'd4, 7'd4}},
    '{CMD_READ,     7'd2,   32'sd0,           1'b0, '{32'sd0,           ST_OK,    7'd0, 7'd0}},
    '{CMD_POP_AT,   7'd1,   32'sd0,           1'b1, '{32'sh7fffffff,    ST_OK,    7'd3, 7'd4}},
    '{CMD_POP_LAST, 7'd0,   32'sd0,           1'b1, '{32'sd12345,       ST_OK,    7'd2, 7'd4}},
    '{CMD_INSERT,   7'd5,   32'sd0,           1'b1, '{32'sd0,           ST_RANGE, 7'd2, 7'd4}},
    '{CMD_SPARE_6,  7'd0,   -32'sd1,          1'b1, '{32'sd0,           ST_OK,    7'd2, 7'd4}},
    '{CMD_SPARE_7,  7'd127, 32'sh7fffffff,    1'b1, '{32'sd0,           ST_OK,    7'd2, 7'd4}},
    '{CMD_POP_AT,   7'd0,   32'sd0,           1'b1, '{32'sd0,           ST_OK,    7'd1, 7'd4}},
    '{CMD_POP_LAST, 7'd0,   32'sd0,           1'b1, '{32'sh80000000,    ST_OK,    7'd0, 7'd1}},
    '{CMD_POP_LAST, 7'd0,   32'sd0,           1'b1, '{32'sd0,           ST_EMPTY, 7'd0, 7'd1}},
    '{CMD_APPEND,   7'd0,   32'sd1,           1'b1, '{32'sd0,           ST_OK,    7'd1, 7'd1}},
    '{CMD_INSERT,   7'd0,   32'sd2,           1'b1, '{32'sd0,           ST_OK,    7'd2, 7'd2}},
    '{CMD_POP_AT,   7'd2,   32'sd0,           1'b1, '{32'sd0,           ST_RANGE, 7'd2, 7'd2}},
    '{CMD_WRITE,    7'd0,   32'sh5a5a5a5a,    1'b0, '{32'sd0,           ST_OK,    7'd0, 7'd0}}
  };

  indexed_list_store_unit #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .position         (position),
    .value            (value),
    .done             (done),
    .result_value     (result_value),
    .status           (status),
    .length           (length),
    .logical_capacity (logical_capacity)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #400000;
    $display("[indexed_list_store_unit] ERROR");
    $finish;
  end

  // ---- shadow list ----

  // Double the capacity until it covers the need, never past the depth
  function automatic void grow_capacity(int needed);
    while (cap_now < needed && cap_now < LIST_DEPTH) begin
      cap_now = (cap_now * 2 > LIST_DEPTH) ? LIST_DEPTH : cap_now * 2;
    end
  endfunction

  // Shrink to the next power of two once the list drops below a quarter
  function automatic void shrink_capacity();
    int c;
    if (word_count * 4 < cap_now) begin
      c = 1;
      while (c < word_count) c = c * 2;
      cap_now = c;
    end
  endfunction

  function automatic void push_word(word_t v);
    grow_capacity(word_count + 1);
    list_words[word_count] = v;
    word_count++;
  endfunction

  function automatic word_t take_word(int at);
    word_t v;
    v = list_words[at];
    for (int i = at; i + 1 < word_count; i++) list_words[i] = list_words[i + 1];
    word_count--;
    shrink_capacity();
    return v;
  endfunction

  function automatic list_reply_t apply_list_command(logic [2:0] cmd, logic [CNT_W-1:0] pos,
                                                     word_t val);
    list_reply_t reply;
    int at;
    reply = '{result_value: '0, status: ST_OK, length: '0, capacity: '0};
    at = int'(pos);
    case (cmd)
      CMD_APPEND: begin
        if (word_count >= LIST_DEPTH) reply.status = ST_FULL;
        else push_word(val);
      end
      CMD_INSERT: begin
        if (at > word_count) begin
          reply.status = ST_RANGE;
        end else if (word_count >= LIST_DEPTH) begin
          reply.status = ST_FULL;
        end else if (at == word_count) begin
          push_word(val);
        end else begin
          // insert in the middle: open a gap, then check for shrink
          grow_capacity(word_count + 1);
          for (int i = word_count; i > at; i--) list_words[i] = list_words[i - 1];
          list_words[at] = val;
          word_count++;
          shrink_capacity();
        end
      end
      CMD_POP_AT: begin
        if (word_count == 0) reply.status = ST_EMPTY;
        else if (at >= word_count) reply.status = ST_RANGE;
        else reply.result_value = take_word(at);
      end
      CMD_POP_LAST: begin
        if (word_count == 0) reply.status = ST_EMPTY;
        else reply.result_value = take_word(word_count - 1);
      end
      CMD_READ: begin
        if (at >= word_count) reply.status = ST_RANGE;
        else reply.result_value = list_words[at];
      end
      CMD_WRITE: begin
        if (at >= word_count) reply.status = ST_RANGE;
        else list_words[at] = val;
      end
      default: ;
    endcase
    reply.length   = CNT_W'(word_count);
    reply.capacity = CNT_W'(cap_now);
    return reply;
  endfunction

  // ---- checking ----

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Compare each result beat with the oldest reply waiting
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && done === 1'b1) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(status), 32'd0);
      end else begin
        want = pending_replies.pop_front();
        if (result_value !== want.result_value)
          report_mismatch("result_value", result_value, want.result_value);
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (length !== want.length)
          report_mismatch("length", 32'(length), 32'(want.length));
        if (logical_capacity !== want.capacity)
          report_mismatch("logical_capacity", 32'(logical_capacity), 32'(want.capacity));
      end
    end
  end

  // ---- stimulus ----

  // Present one command and hold it until the beat is taken
  task automatic issue_command(logic [2:0] cmd, logic [CNT_W-1:0] pos, word_t val,
                               output list_reply_t predicted);
    start    <= 1'b1;
    command  <= cmd;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (busy === 1'b1) @(posedge clk);
    predicted = apply_list_command(cmd, pos, val);
  endtask

  // Random sender gap, idle_pct in a hundred
  task automatic sender_gap(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold off until every reply has come back
  task automatic wait_for_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_command(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 45) return CMD_APPEND;
        if (r < 75) return CMD_INSERT;
        if (r < 80) return CMD_POP_AT;
        if (r < 83) return CMD_POP_LAST;
        if (r < 91) return CMD_READ;
        if (r < 98) return CMD_WRITE;
      end
      MODE_DRAIN: begin
        if (r < 8)  return CMD_APPEND;
        if (r < 15) return CMD_INSERT;
        if (r < 50) return CMD_POP_AT;
        if (r < 75) return CMD_POP_LAST;
        if (r < 87) return CMD_READ;
        if (r < 98) return CMD_WRITE;
      end
      default: begin
        if (r < 20) return CMD_APPEND;
        if (r < 38) return CMD_INSERT;
        if (r < 55) return CMD_POP_AT;
        if (r < 65) return CMD_POP_LAST;
        if (r < 80) return CMD_READ;
        if (r < 96) return CMD_WRITE;
      end
    endcase
    return ($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
  endfunction

  // Mostly in range for the command, now and then anywhere in the field
  function automatic logic [CNT_W-1:0] pick_position(logic [2:0] cmd);
    if ($urandom_range(9) == 0) return CNT_W'($urandom_range(POS_MAX));
    if (cmd == CMD_INSERT) return CNT_W'($urandom_range(word_count));
    if (word_count == 0) return '0;
    return CNT_W'($urandom_range(word_count - 1));
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    list_reply_t      predicted;
    logic [2:0]       cmd;
    logic [CNT_W-1:0] pos;
    int               phase;
    int               idle_pct;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      sender_gap(7);
      issue_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                    predicted);
      if (directed_rows[i].has_literal) pending_replies.push_back(directed_rows[i].reply);
      else pending_replies.push_back(predicted);
    end
    wait_for_replies();

    // random part: fill, drain and mixed segments under three idling phases
    phase = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n * 3 / RANDOM_ITEMS != phase) begin
        phase = n * 3 / RANDOM_ITEMS;
        wait_for_replies();
      end
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
      sender_gap(idle_pct);
      cmd = pick_command((n / SEGMENT_LEN) % (MODE_MIXED + 1));
      pos = pick_position(cmd);
      issue_command(cmd, pos, pick_value(), predicted);
      pending_replies.push_back(predicted);
    end

    wait_for_replies();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[indexed_list_store_unit] OK");
    end else begin
      $display("[indexed_list_store_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store_unit.sv
rtl/ils_checker.sv
verif/testbench.sv
